>>> rtl/ralp_pkg.sv
// shared types and constants for the reflectance array line position block
// no dependencies
package ralp_pkg;

  localparam int NUM_SENSORS = 9;
  localparam int ADC_BITS    = 10;
  localparam int IDX_W       = $clog2(NUM_SENSORS);
  localparam int POS_W       = 12;
  localparam int MOM_W       = 8 + IDX_W + IDX_W + 8;   // moment shifted by 8
  localparam int MASS_W      = 8 + IDX_W + 1;

  // shared divider sizing, wide enough for the centroid divide
  localparam int DIV_NUM_W   = MOM_W;
  localparam int DIV_DEN_W   = MASS_W;
  localparam int DIV_CNT_W   = $clog2(DIV_NUM_W + 1);

  localparam logic [7:0] RESET_THRESHOLD = 8'd200;
  localparam logic [7:0] NORM_FULL       = 8'd255;

  // register indexes
  localparam logic [0:0] REG_TRACK     = 1'b0;
  localparam logic [0:0] REG_THRESHOLD = 1'b1;

  localparam int IN_W  = ((1 + NUM_SENSORS * ADC_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((NUM_SENSORS * 8 + POS_W + 1 + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_NORM,
    ST_SUM,
    ST_POS,
    ST_DIV,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_ext;
    logic load;
    logic norm_start;
    logic sum_step;
    logic pos_start;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic norm_done;
    logic sum_last;
    logic pos_done;
    logic seen;
  } status_t;

endpackage

>>> rtl/ralp_div.sv
// restoring divider, one quotient bit per cycle
// depends on ralp_pkg
module ralp_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ralp_pkg::DIV_NUM_W-1:0] num,
  input  logic [ralp_pkg::DIV_DEN_W-1:0] den,
  output logic [ralp_pkg::DIV_NUM_W-1:0] quo,
  output logic                           done
);
  import ralp_pkg::*;

  logic [DIV_DEN_W:0]   rem;
  logic [DIV_NUM_W-1:0] q;
  logic [DIV_DEN_W-1:0] d;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIV_DEN_W:0]   trial;

  assign trial = {rem[DIV_DEN_W-1:0], q[DIV_NUM_W-1]};

  // shift-subtract step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= num;
      d   <= den;
    end else if (busy) begin
      if (trial >= {1'b0, d}) begin
        rem <= trial - {1'b0, d};
        q   <= {q[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quo = q;

endmodule

>>> rtl/ralp_datapath.sv
// extrema store, per-lane normalizing dividers, centroid accumulation and divide
// depends on ralp_pkg, ralp_div
module ralp_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  ralp_pkg::cmd_t              cmd,
  output ralp_pkg::status_t           status,
  input  logic [ralp_pkg::IN_W-1:0]   in_data,
  input  logic                        track_extrema,
  input  logic [7:0]                  line_threshold,
  output logic [ralp_pkg::OUT_W-1:0]  out_data
);
  import ralp_pkg::*;

  logic [7:0] low_ext  [NUM_SENSORS];
  logic [7:0] high_ext [NUM_SENSORS];
  logic [7:0] xs       [NUM_SENSORS];
  logic [7:0] norm     [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] lane_done;
  logic [NUM_SENSORS-1:0] lane_pending;
  logic [7:0]  lane_q  [NUM_SENSORS];
  logic [IDX_W-1:0] sidx;
  logic [MASS_W-1:0] mass;
  logic [MOM_W-1:0]  moment;
  logic [7:0]        peak;
  logic [POS_W-1:0]  last_position;
  logic              seen;
  logic [MOM_W-1:0]  pos_q;
  logic              pos_done;
  logic [OUT_W-1:0]  out_next;

  // cut samples and update extrema
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_ext) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        low_ext[i]  <= 8'hFF;
        high_ext[i] <= 8'h00;
      end
    end else if (cmd.load && track_extrema) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        if (in_data[1 + i*ADC_BITS + ADC_BITS - 8 +: 8] < low_ext[i])
          low_ext[i] <= in_data[1 + i*ADC_BITS + ADC_BITS - 8 +: 8];
        if (in_data[1 + i*ADC_BITS + ADC_BITS - 8 +: 8] > high_ext[i])
          high_ext[i] <= in_data[1 + i*ADC_BITS + ADC_BITS - 8 +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < NUM_SENSORS; i++)
        xs[i] <= in_data[1 + i*ADC_BITS + ADC_BITS - 8 +: 8];
    end
  end

  // one divider per lane
  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
    logic [15:0] lnum;
    logic [DIV_NUM_W-1:0] lq;
    logic [7:0]  span;
    logic [7:0]  dx;
    assign span = high_ext[g] - low_ext[g];
    assign dx   = xs[g] - low_ext[g];
    assign lnum = {dx, 8'h00} - {8'h00, dx};
    ralp_div u_div (
      .clk(clk), .rst(rst), .start(cmd.norm_start),
      .num(DIV_NUM_W'(lnum)), .den(DIV_DEN_W'(span)), .quo(lq), .done(lane_done[g])
    );
    assign lane_q[g] = (lq > DIV_NUM_W'(255)) ? NORM_FULL : lq[7:0];

    always_ff @(posedge clk) begin
      if (lane_done[g]) begin
        if (high_ext[g] <= low_ext[g] || xs[g] <= low_ext[g])
          norm[g] <= 8'h00;
        else if (xs[g] >= high_ext[g])
          norm[g] <= NORM_FULL;
        else
          norm[g] <= lane_q[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) lane_pending <= '0;
    else lane_pending <= lane_done;
  end

  // sensor walk: mass, moment and peak
  always_ff @(posedge clk) begin
    if (rst || cmd.norm_start) begin
      sidx   <= '0;
      mass   <= '0;
      moment <= '0;
      peak   <= '0;
    end else if (cmd.sum_step) begin
      sidx   <= sidx + 1'b1;
      mass   <= mass + MASS_W'(norm[sidx]);
      moment <= moment + (MOM_W'(12'(norm[sidx]) * 12'(sidx)) << 8);
      if (norm[sidx] > peak) peak <= norm[sidx];
    end
  end
  assign seen = (peak > line_threshold) && (mass != '0);

  assign status = '{norm_done: lane_pending[0],
                    sum_last:  (sidx == IDX_W'(NUM_SENSORS - 1)),
                    pos_done:  pos_done,
                    seen:      seen};

  ralp_div u_pos_div (
    .clk(clk), .rst(rst), .start(cmd.pos_start),
    .num(moment), .den(mass), .quo(pos_q), .done(pos_done)
  );

  always_ff @(posedge clk) begin
    if (rst) last_position <= '0;
    else if (pos_done && seen) last_position <= pos_q[POS_W-1:0];
  end

  // result packing
  always_comb begin
    out_next = '0;
    for (int i = 0; i < NUM_SENSORS; i++)
      out_next[i*8 +: 8] = norm[i];
    out_next[NUM_SENSORS*8 +: POS_W] = last_position;
    out_next[NUM_SENSORS*8 + POS_W]  = peak > line_threshold;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data <= out_next;
  end

endmodule

>>> rtl/ralp_ctrl.sv
// controller state machine sequencing one frame through the datapath
// depends on ralp_pkg
module ralp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              in_kind,
  input  logic              out_taken,
  input  ralp_pkg::status_t status,
  output ralp_pkg::cmd_t    cmd,
  output logic              in_ready,
  output logic              out_valid
);
  import ralp_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_taken;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (in_kind) cmd.clear_ext = 1'b1;
          else begin
            cmd.load   = 1'b1;
            state_next = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd.norm_start = 1'b1;
        state_next     = ST_NORM;
      end
      ST_NORM: if (status.norm_done) state_next = ST_SUM;
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (status.sum_last) state_next = ST_POS;
      end
      ST_POS: begin
        if (!status.seen) state_next = ST_OUT;
        else begin
          cmd.pos_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      // wait for the centroid divide to land in last_position
      ST_DIV: if (status.pos_done) state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid_next) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/reflectance_array_line_position.sv
// top level: stream ports, configuration registers, controller and datapath
// depends on ralp_pkg, ralp_ctrl, ralp_datapath
//
// A sample frame is loaded, the per-sensor normalizing dividers are started and
// run, and their quotients are latched and flagged done; the sensors are then
// walked for mass, moment and peak, the controller decides whether the line is
// seen, the centroid divider runs only when the line is seen, and the output
// register is loaded. A stalled output delays that load until the previous
// result is taken. One frame is in flight at a time; a finished result sits in
// the output register while the next request is taken. A start-calibration
// request resets the extrema and gives no result.
module reflectance_array_line_position (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [ralp_pkg::IN_W-1:0]  s_tdata,  // raw_0 .. raw_8 (10 bits each)
  input  logic                       s_tuser,  // kind
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [ralp_pkg::OUT_W-1:0] m_tdata,  // norm_0..norm_8, line_position, line_seen
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [7:0]                 cfg_data
);
  import ralp_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    track_extrema;
  logic [7:0] line_threshold;
  logic    in_fire;
  logic [IN_W-1:0] in_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      track_extrema  <= 1'b0;
      line_threshold <= RESET_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRACK:     track_extrema  <= cfg_data[0];
        REG_THRESHOLD: line_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_fire = s_tvalid && s_tready;
  assign in_data = {s_tdata[IN_W-2:0], s_tuser};

  ralp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_kind(s_tuser),
    .out_taken(m_tvalid && m_tready), .status(status), .cmd(cmd),
    .in_ready(s_tready), .out_valid(m_tvalid)
  );

  ralp_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .in_data(in_data),
    .track_extrema(track_extrema), .line_threshold(line_threshold),
    .out_data(m_tdata)
  );

`ifndef SYNTHESIS
  a_no_load_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(m_tvalid && !m_tready)) else $error("result overwritten");
  a_calib_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tuser && !m_tvalid) |=> !m_tvalid) else $error("calibration gave result");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !s_tuser) |=> !s_tready) else $error("took request while busy");
`endif

endmodule

>>> dv/reflectance_array_line_position_tb.sv
// testbench for the reflectance array line position block: frames and calibration requests
// with random stalls, results checked against a behavioral predictor; depends on ralp_pkg
`timescale 1ns / 100ps

module reflectance_array_line_position_tb;
  import ralp_pkg::*;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_CAL   = 1'b1;

  typedef struct {
    logic       kind;
    logic [9:0] raw [NUM_SENSORS];
  } frame_t;

  typedef struct {
    logic [7:0]  norm [NUM_SENSORS];
    logic [11:0] pos;
    logic        seen;
  } line_result_t;

  logic clk, rst;
  logic s_tvalid, s_tready, s_tuser;
  logic [IN_W-1:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_we, cfg_index;
  logic [7:0] cfg_data;

  reflectance_array_line_position dut (.*);

  // predictor state
  logic [7:0]  pred_low [NUM_SENSORS];
  logic [7:0]  pred_high [NUM_SENSORS];
  logic [11:0] pred_pos;
  logic        pred_track;
  logic [7:0]  pred_thresh;

  frame_t       pending_frames[$];
  line_result_t expected_results[$];
  int errors = 0, frames_sent = 0, cals_sent = 0, results_seen = 0, seen_count = 0;
  bit idle_off = 0;
  int s_gap = 0, m_stall = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic logic [7:0] scale_sample(input logic [7:0] x, input logic [7:0] lo,
                                              input logic [7:0] hi);
    if (hi <= lo || x <= lo) return 8'd0;
    if (x >= hi) return NORM_FULL;
    return 8'((int'(x - lo) * 255) / int'(hi - lo));
  endfunction

  // model one accepted request, queue its result if any
  task automatic predict_line(input frame_t f);
    line_result_t r;
    int mass, moment, peak;
    logic [7:0] x;
    mass = 0; moment = 0; peak = 0;
    if (f.kind == KIND_CAL) begin
      foreach (pred_low[i]) begin
        pred_low[i] = 8'hff;
        pred_high[i] = 8'h00;
      end
      return;
    end
    for (int i = 0; i < NUM_SENSORS; i++) begin
      x = f.raw[i][9:2];
      if (pred_track) begin
        if (x < pred_low[i]) pred_low[i] = x;
        if (x > pred_high[i]) pred_high[i] = x;
      end
      r.norm[i] = scale_sample(x, pred_low[i], pred_high[i]);
      mass += r.norm[i];
      moment += r.norm[i] * i;
      if (r.norm[i] > peak) peak = r.norm[i];
    end
    r.seen = peak > pred_thresh;
    if (r.seen && mass != 0) pred_pos = 12'((moment * 256) / mass);
    r.pos = pred_pos;
    if (r.seen) seen_count++;
    expected_results.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_line(pending_frames.pop_front());
      end
      if (!(s_tvalid && !s_tready)) begin
        if (s_gap > 0) begin
          s_gap--;
          s_tvalid <= 0;
        end else if (!idle_off && $urandom_range(0, 7) == 0) begin
          s_gap = $urandom_range(0, 4);
          s_tvalid <= 0;
        end else if (pending_frames.size() > (s_tvalid && s_tready ? 0 : 0)
                     && pending_frames.size() != 0) begin
          s_tvalid <= 1;
          s_tuser <= pending_frames[0].kind;
          for (int i = 0; i < NUM_SENSORS; i++) s_tdata[i*10 +: 10] <= pending_frames[0].raw[i];
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // monitor and back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          line_result_t e;
          e = expected_results.pop_front();
          for (int i = 0; i < NUM_SENSORS; i++)
            if (m_tdata[i*8 +: 8] !== e.norm[i]) report($sformatf("norm_%0d", i),
                                                        m_tdata[i*8 +: 8], e.norm[i]);
          if (m_tdata[72 +: 12] !== e.pos) report("line_position", m_tdata[72 +: 12], e.pos);
          if (m_tdata[84] !== e.seen) report("line_seen", m_tdata[84], e.seen);
        end
      end
      if (m_stall > 0) begin
        m_stall--;
        m_tready <= 0;
      end else if (!idle_off && $urandom_range(0, 5) == 0) begin
        m_stall = $urandom_range(0, 4);
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_TRACK) pred_track = val[0];
    else pred_thresh = val;
  endtask

  task automatic add_frame(input logic kind, input int mode);
    frame_t f;
    int peak_at;
    f.kind = kind;
    peak_at = $urandom_range(0, NUM_SENSORS - 1);
    for (int i = 0; i < NUM_SENSORS; i++) begin
      case (mode)
        0: f.raw[i] = 10'($urandom);
        1: f.raw[i] = 10'd0;
        2: f.raw[i] = 10'h3ff;
        // a line under a few neighboring sensors on a light floor
        default: f.raw[i] = (i >= peak_at - 1 && i <= peak_at + 1) ?
                   10'($urandom_range(700, 1023)) : 10'($urandom_range(0, 300));
      endcase
    end
    if (kind == KIND_CAL) cals_sent++; else frames_sent++;
    pending_frames.push_back(f);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while ((pending_frames.size() != 0 || s_tvalid || expected_results.size() != 0)
           && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  initial begin
    rst = 1; s_tvalid = 0; s_tuser = 0; s_tdata = '0; m_tready = 0;
    cfg_we = 0; cfg_index = REG_TRACK; cfg_data = 0;
    foreach (pred_low[i]) begin
      pred_low[i] = 8'hff;
      pred_high[i] = 8'h00;
    end
    pred_pos = 0; pred_track = 0; pred_thresh = RESET_THRESHOLD;
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed: untracked frames at extremes, then a calibration sweep
    add_frame(KIND_FRAME, 1);
    add_frame(KIND_FRAME, 2);
    drain();
    write_reg(REG_TRACK, 8'd1);
    write_reg(REG_THRESHOLD, 8'd0);
    add_frame(KIND_CAL, 0);
    add_frame(KIND_FRAME, 1);
    add_frame(KIND_FRAME, 2);
    add_frame(KIND_FRAME, 0);
    for (int k = 0; k < 6; k++) add_frame(KIND_FRAME, 3);
    drain();
    write_reg(REG_THRESHOLD, 8'd255);
    add_frame(KIND_FRAME, 2);
    add_frame(KIND_FRAME, 3);
    drain();
    write_reg(REG_TRACK, 8'd0);
    write_reg(REG_THRESHOLD, 8'd254);
    for (int k = 0; k < 5; k++) add_frame(KIND_FRAME, k % 4);
    drain();

    // random phases with varied settings
    for (int p = 0; p < 10; p++) begin
      if (p == 8) idle_off = 1;
      write_reg(REG_TRACK, 8'($urandom_range(0, 1)));
      write_reg(REG_THRESHOLD, (p == 2) ? 8'd0 : (p == 5) ? 8'd255 : 8'($urandom_range(0, 255)));
      for (int k = 0; k < 73; k++) begin
        if ($urandom_range(0, 15) == 0) add_frame(KIND_CAL, 0);
        else add_frame(KIND_FRAME, $urandom_range(0, 9) < 7 ? 3 : $urandom_range(0, 2));
      end
      drain();
    end

    if (pending_frames.size() != 0 || expected_results.size() != 0) begin
      $display("simulation failed");
      $finish;
    end
    $display("covered %0d frames and %0d calibration requests, %0d results, %0d with line seen",
             frames_sent, cals_sent, results_seen, seen_count);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
